### sv/tsb_pkg.sv
// tsb_pkg: shared types and constants for the texture slot batcher
// no dependencies; imported by tsb_cell, tsb_ctrl and texture_slot_batcher_core
`timescale 1ns / 1ps

package tsb_pkg;

    localparam int TEX_W      = 32;
    localparam int SLOT_IDX_W = 6;   // covers up to 64 slots
    localparam int USED_W     = 7;   // slot count, 0 .. 64
    localparam int LIMIT_W    = 6;
    localparam int CALL_W     = 16;
    localparam int TOTAL_W    = 24;
    localparam int OUT_SLOT_W = 5;

    localparam logic [CALL_W-1:0]  CALL_MAX  = 16'hFFFF;
    localparam logic [TOTAL_W-1:0] INDEX_MAX = 24'hFFFFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd32;

    localparam logic ACT_QUAD    = 1'b0;
    localparam logic ACT_REBUILD = 1'b1;

    // request travelling down the slot chain
    typedef struct packed {
        logic                  active;
        logic [TEX_W-1:0]      tex;
        logic                  found;
        logic [SLOT_IDX_W-1:0] slot;
    } tsb_search_t;

    // slot write from the controller to the chain
    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] slot;
        logic [TEX_W-1:0]      tex;
    } tsb_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } tsb_state_t;

endpackage

### sv/tsb_cell.sv
// tsb_cell: one texture slot of the search chain, with its compare stage
// depends on tsb_pkg
`timescale 1ns / 1ps

module tsb_cell
    import tsb_pkg::*;
#(
    parameter int SLOT_ID = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  tsb_search_t search_in,
    input  logic [USED_W-1:0] used,
    input  tsb_wr_t     wr,
    output tsb_search_t search_out
);

    localparam logic [USED_W-1:0]     ID_CNT = USED_W'(SLOT_ID);
    localparam logic [SLOT_IDX_W-1:0] ID_IDX = SLOT_IDX_W'(SLOT_ID);

    logic [TEX_W-1:0] tex_reg;
    logic             active_reg;
    logic [TEX_W-1:0] fwd_tex_reg;
    logic             found_reg;
    logic [SLOT_IDX_W-1:0] slot_reg;
    logic             hit;

    // only filled slots take part in the compare
    assign hit = (ID_CNT < used) && (tex_reg == search_in.tex);

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.slot == ID_IDX))
        begin
            tex_reg <= wr.tex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= search_in.active;
        end
    end

    // earlier slots win, so a found request passes through untouched
    always_ff @(posedge clk)
    begin
        fwd_tex_reg <= search_in.tex;
        found_reg   <= search_in.found | hit;
        slot_reg    <= search_in.found ? search_in.slot : ID_IDX;
    end

    assign search_out = '{active: active_reg, tex: fwd_tex_reg,
                          found: found_reg, slot: slot_reg};

endmodule

### sv/tsb_ctrl.sv
// tsb_ctrl: request handshake, slot and draw call bookkeeping, result register
// depends on tsb_pkg; drives the head of the tsb_cell chain and reads its tail
`timescale 1ns / 1ps

module tsb_ctrl
    import tsb_pkg::*;
#(
    parameter int MAX_SLOTS        = 32,
    parameter int INDICES_PER_QUAD = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [TEX_W-1:0]      texture_id,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_SLOT_W-1:0] slot_index,
    output logic [CALL_W-1:0]     draw_call_number,
    output logic                  started_new_call,
    output logic                  added_texture,
    output logic [TOTAL_W-1:0]    call_index_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LIMIT_W-1:0]    cfg_data,
    output tsb_search_t           chain_head,
    input  tsb_search_t           chain_tail,
    output logic [USED_W-1:0]     used,
    output tsb_wr_t               wr
);

    localparam logic [USED_W-1:0]  SLOTS_MAX = USED_W'(MAX_SLOTS);
    localparam logic [TOTAL_W-1:0] IPQ       = TOTAL_W'(INDICES_PER_QUAD);
    localparam logic [TOTAL_W-1:0] TOTAL_TOP = INDEX_MAX - IPQ;

    tsb_state_t state_reg, state_next;

    logic [LIMIT_W-1:0]  limit_reg;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [CALL_W-1:0]   call_reg, call_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                launch_active_reg;
    logic [TEX_W-1:0]    launch_tex_reg;
    tsb_search_t         hold_reg;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_SLOT_W-1:0] out_slot_reg;
    logic [CALL_W-1:0]   out_call_reg;
    logic                out_new_reg;
    logic                out_added_reg;
    logic [TOTAL_W-1:0]  out_total_reg;

    logic                accept;
    logic                commit;
    logic                new_call;
    logic [USED_W-1:0]   lim_eff;
    logic [SLOT_IDX_W-1:0] slot_sel;
    logic [USED_W-1:0]   slot_wide;
    logic [TOTAL_W-1:0]  total_base;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign commit    = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // a zero limit acts as one, anything beyond the slot count as the slot count
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim_eff = USED_W'(1);
        end
        else if (USED_W'(limit_reg) > SLOTS_MAX)
        begin
            lim_eff = SLOTS_MAX;
        end
        else
        begin
            lim_eff = USED_W'(limit_reg);
        end
    end

    always_comb
    begin
        new_call   = !hold_reg.found && (used_reg >= lim_eff);
        if (hold_reg.found)
        begin
            slot_sel = hold_reg.slot;
        end
        else if (new_call)
        begin
            slot_sel = '0;
        end
        else
        begin
            slot_sel = used_reg[SLOT_IDX_W-1:0];
        end
        slot_wide  = USED_W'(slot_sel);
        total_base = new_call ? '0 : total_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        call_next      = call_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_REBUILD)
                    begin
                        used_next = '0;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (chain_tail.active)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (!hold_reg.found)
                    begin
                        used_next = slot_wide + USED_W'(1);
                    end
                    if (new_call && (call_reg != CALL_MAX))
                    begin
                        call_next = call_reg + CALL_W'(1);
                    end
                    total_next = (total_base > TOTAL_TOP) ? INDEX_MAX : total_base + IPQ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            limit_reg         <= LIMIT_RST;
            used_reg          <= '0;
            call_reg          <= '0;
            total_reg         <= '0;
            out_valid_reg     <= 1'b0;
            launch_active_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            used_reg          <= used_next;
            call_reg          <= call_next;
            total_reg         <= total_next;
            out_valid_reg     <= out_valid_next;
            launch_active_reg <= accept && (action == ACT_QUAD);
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            launch_tex_reg <= texture_id;
        end
        if ((state_reg == ST_SEARCH) && chain_tail.active)
        begin
            hold_reg <= chain_tail;
        end
        if (commit)
        begin
            out_slot_reg  <= OUT_SLOT_W'(slot_wide);
            out_call_reg  <= call_next;
            out_new_reg   <= new_call;
            out_added_reg <= !hold_reg.found;
            out_total_reg <= total_next;
        end
    end

    assign chain_head = '{active: launch_active_reg, tex: launch_tex_reg,
                          found: 1'b0, slot: '0};
    assign used = used_reg;
    assign wr   = '{en: commit && !hold_reg.found, slot: slot_sel, tex: hold_reg.tex};

    assign out_valid        = out_valid_reg;
    assign slot_index       = out_slot_reg;
    assign draw_call_number = out_call_reg;
    assign started_new_call = out_new_reg;
    assign added_texture    = out_added_reg;
    assign call_index_count = out_total_reg;

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= SLOTS_MAX)
        else $error("slot count beyond slot storage");

    a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain_tail.active |-> (state_reg == ST_SEARCH))
        else $error("chain delivered a request outside the search phase");

    a_hit_below_used: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && hold_reg.found) |-> (USED_W'(hold_reg.slot) < used_reg))
        else $error("match reported in an empty slot");

    a_new_call_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && new_call) |=> (used_reg == USED_W'(1)))
        else $error("new draw call did not restart the slot count");

endmodule

### sv/texture_slot_batcher_core.sv
// texture_slot_batcher_core: top level, a chain of slot cells under one controller
// depends on tsb_pkg, tsb_cell, tsb_ctrl
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_stall  | action, texture_id
//  out     | out_valid / out_stall| slot_index, draw_call_number, started_new_call,
//          |                      | added_texture, call_index_count
//  cfg     | cfg_valid / cfg_ready| cfg_data (slot_limit)
//
//  a quad request is registered at the chain head, walks the slot chain one cell
//  a cycle, is captured from the tail into a hold register, and then updates state
//  and loads the result register once out_stall allows. a rebuild gives no result.
//  in_stall is high while a quad is in flight; a finished result waiting on
//  out_stall does not block the next request. reset empties all slots and counters
//  and sets slot_limit to 32; slot contents themselves are not cleared.
`timescale 1ns / 1ps

module texture_slot_batcher_core
    import tsb_pkg::*;
#(
    parameter int MAX_SLOTS        = 32,
    parameter int INDICES_PER_QUAD = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [TEX_W-1:0]      texture_id,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_SLOT_W-1:0] slot_index,
    output logic [CALL_W-1:0]     draw_call_number,
    output logic                  started_new_call,
    output logic                  added_texture,
    output logic [TOTAL_W-1:0]    call_index_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LIMIT_W-1:0]    cfg_data
);

    tsb_search_t       link [MAX_SLOTS+1];
    logic [USED_W-1:0] used;
    tsb_wr_t           wr;

    tsb_ctrl #(
        .MAX_SLOTS        (MAX_SLOTS),
        .INDICES_PER_QUAD (INDICES_PER_QUAD)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .texture_id       (texture_id),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .slot_index       (slot_index),
        .draw_call_number (draw_call_number),
        .started_new_call (started_new_call),
        .added_texture    (added_texture),
        .call_index_count (call_index_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .chain_head       (link[0]),
        .chain_tail       (link[MAX_SLOTS]),
        .used             (used),
        .wr               (wr)
    );

    // slot 0 sits at the head so the first match in slot order wins
    for (genvar i = 0; i < MAX_SLOTS; i++)
    begin : g_cell
        tsb_cell #(
            .SLOT_ID (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .search_in  (link[i]),
            .used       (used),
            .wr         (wr),
            .search_out (link[i+1])
        );
    end

endmodule
